[hw/rtl/jrdz_pkg.sv]
// Package: payload types and fixed-point constants for the radial dead-zone core.
package jrdz_pkg;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
    } jrdz_in_t;

    typedef struct packed {
        logic signed [15:0] scaled_x;
        logic signed [15:0] scaled_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic               in_dead_zone;
    } jrdz_out_t;

    localparam int QW         = 17;   // quotient bits kept before saturation
    localparam int ROOT_W     = 24;   // width of the Q.23 length
    localparam int RAD_W      = 48;   // width of the square root radicand
    localparam int SQRT_LAT   = ROOT_W + 1;
    localparam int DIV_LAT    = QW + 1;
    localparam int PADDR_W    = 3;
    localparam logic [PADDR_W-1:0] REG_DEAD_ZONE = 3'd0;
    localparam logic [14:0] DEAD_ZONE_RESET = 15'd6554;

endpackage

[hw/rtl/jrdz_sqrt.sv]
// Pipelined restoring integer square root, one result bit per stage.
module jrdz_sqrt
    import jrdz_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  v_reg    [0:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0]    <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_step
            logic [REM_W+1:0] shifted;
            logic [REM_W+1:0] trial;
            logic             ge;
            assign shifted = {rem_reg[k], v_reg[k][RAD_W-1 -: 2]};
            assign trial   = {2'b00, root_reg[k], 2'b01};
            assign ge      = shifted >= trial;
            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[k+1]    <= {v_reg[k][RAD_W-3:0], 2'b00};
                    rem_reg[k+1]  <= ge ? REM_W'(shifted - trial) : REM_W'(shifted);
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W];

endmodule

[hw/rtl/jrdz_div.sv]
// Pipelined restoring divider with a quotient of QW bits and an overflow flag.
module jrdz_div
    import jrdz_pkg::*;
#(
    parameter int NW = 57,
    parameter int DW = 41
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          sat
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic          sat_reg [0:QW];

    // The quotient overflows QW bits when the high part already reaches the divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg[0] <= CW'(num[NW-1:QW]) >= CW'(den);
            rem_reg[0] <= DW'(num[NW-1:QW]);
            low_reg[0] <= num[QW-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_step
            logic [DW:0] trial;
            logic        ge;
            assign trial = {rem_reg[i], low_reg[i][QW-1]};
            assign ge    = trial >= {1'b0, den_reg[i]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i+1] <= ge ? DW'(trial - {1'b0, den_reg[i]}) : trial[DW-1:0];
                    low_reg[i+1] <= {low_reg[i][QW-2:0], 1'b0};
                    den_reg[i+1] <= den_reg[i];
                    q_reg[i+1]   <= {q_reg[i][QW-2:0], ge};
                    sat_reg[i+1] <= sat_reg[i];
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW];
    assign sat = sat_reg[QW];

endmodule

[hw/rtl/joystick_radial_deadzone_core.sv]
// Top level: stick sample pipeline with square root, dividers and APB register.
//
// Takes one stick sample per clock while the result channel is not stalled, and
// returns one result per sample, in order. The pipeline is made of the 25-stage
// square root and the 18-stage dividers that form the direction and the rescaled
// axes; five more stages compute the squared length, the products and the division
// operands, and one is the output register. A stall on the result channel freezes
// the whole pipeline. The dead-zone register sits at byte address 0 and is to be
// written only while the pipeline is empty.
module joystick_radial_deadzone_core
    import jrdz_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jrdz_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output jrdz_out_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef struct packed {
        logic [16:0] ax;
        logic [16:0] ay;
        logic        nx;
        logic        ny;
        logic        dead;
        logic        zero;
    } side_t;

    logic        adv;
    logic [14:0] dz_reg;

    // Configuration port.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg <= DEAD_ZONE_RESET;
        end else if (psel && penable && pwrite && paddr == REG_DEAD_ZONE) begin
            dz_reg <= pwdata[14:0];
        end
    end
    assign prdata = (paddr == REG_DEAD_ZONE) ? {17'd0, dz_reg} : 32'd0;

    logic      m_valid_reg;
    jrdz_out_t m_data_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Stage 1: magnitudes and signs.
    logic [16:0] xe, ye;
    logic        v1_reg;
    side_t       s1_reg;
    assign xe = {s_data.stick_x[15], s_data.stick_x};
    assign ye = {s_data.stick_y[15], s_data.stick_y};
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg.ax   <= xe[16] ? (~xe + 17'd1) : xe;
            s1_reg.ay   <= ye[16] ? (~ye + 17'd1) : ye;
            s1_reg.nx   <= xe[16];
            s1_reg.ny   <= ye[16];
            s1_reg.dead <= 1'b0;
            s1_reg.zero <= 1'b0;
        end
    end

    // Stage 2: squares.
    logic        v2_reg;
    side_t       s2_reg;
    logic [33:0] sqx_reg, sqy_reg;
    logic [29:0] dzsq_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg   <= s1_reg;
            sqx_reg  <= s1_reg.ax * s1_reg.ax;
            sqy_reg  <= s1_reg.ay * s1_reg.ay;
            dzsq_reg <= dz_reg * dz_reg;
        end
    end

    // Stage 3: squared length, dead-zone and zero-vector tests.
    logic        v3_reg;
    side_t       s3_reg;
    logic [31:0] len2_reg;
    logic [34:0] len2_sum;
    assign len2_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_reg.ax   <= s2_reg.ax;
            s3_reg.ay   <= s2_reg.ay;
            s3_reg.nx   <= s2_reg.nx;
            s3_reg.ny   <= s2_reg.ny;
            s3_reg.dead <= len2_sum < {5'd0, dzsq_reg};
            s3_reg.zero <= len2_sum == '0;
            len2_reg    <= len2_sum[31:0];
        end
    end

    logic [ROOT_W-1:0] len;
    jrdz_sqrt u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .rad  ({len2_reg, 16'd0}),
        .root (len)
    );

    side_t side_a_reg [0:SQRT_LAT-1];
    logic  va_reg     [0:SQRT_LAT-1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_a_reg[0] <= s3_reg;
            for (int j = 1; j < SQRT_LAT; j++) side_a_reg[j] <= side_a_reg[j-1];
        end
    end

    // Stage 4: span, denominator and axis products.
    logic        v4_reg;
    side_t       s4_reg;
    logic [23:0] len4_reg;
    logic [39:0] dens_reg;
    logic [40:0] px_reg, py_reg;
    logic [23:0] span;
    logic [15:0] fac;
    assign span = len - {1'b0, dz_reg, 8'd0};
    assign fac  = 16'h8000 - {1'b0, dz_reg};
    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_reg   <= side_a_reg[SQRT_LAT-1];
            len4_reg <= len;
            dens_reg <= len * fac;
            px_reg   <= side_a_reg[SQRT_LAT-1].ax * span;
            py_reg   <= side_a_reg[SQRT_LAT-1].ay * span;
        end
    end

    // Stage 5: rounding operands, 2*num + den over 2*den.
    logic        v5_reg;
    side_t       s5_reg;
    logic [56:0] nsx_reg, nsy_reg;
    logic [40:0] ds_reg;
    logic [40:0] ndx_reg, ndy_reg;
    logic [24:0] dd_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_reg  <= s4_reg;
            nsx_reg <= {px_reg, 16'd0} + 57'(dens_reg);
            nsy_reg <= {py_reg, 16'd0} + 57'(dens_reg);
            ds_reg  <= {dens_reg, 1'b0};
            ndx_reg <= {s4_reg.ax, 24'd0} + 41'(len4_reg);
            ndy_reg <= {s4_reg.ay, 24'd0} + 41'(len4_reg);
            dd_reg  <= {len4_reg, 1'b0};
        end
    end

    logic [QW-1:0] qsx, qsy, qdx, qdy;
    logic          tsx, tsy, tdx, tdy;
    jrdz_div #(.NW(57), .DW(41)) u_div_sx (
        .aclk(aclk), .en(adv), .num(nsx_reg), .den(ds_reg), .quo(qsx), .sat(tsx));
    jrdz_div #(.NW(57), .DW(41)) u_div_sy (
        .aclk(aclk), .en(adv), .num(nsy_reg), .den(ds_reg), .quo(qsy), .sat(tsy));
    jrdz_div #(.NW(41), .DW(25)) u_div_dx (
        .aclk(aclk), .en(adv), .num(ndx_reg), .den(dd_reg), .quo(qdx), .sat(tdx));
    jrdz_div #(.NW(41), .DW(25)) u_div_dy (
        .aclk(aclk), .en(adv), .num(ndy_reg), .den(dd_reg), .quo(qdy), .sat(tdy));

    side_t side_b_reg [0:DIV_LAT-1];
    logic  vb_reg     [0:DIV_LAT-1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_b_reg[0] <= s5_reg;
            for (int j = 1; j < DIV_LAT; j++) side_b_reg[j] <= side_b_reg[j-1];
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int j = 0; j < SQRT_LAT; j++) va_reg[j] <= 1'b0;
            for (int j = 0; j < DIV_LAT; j++) vb_reg[j] <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            va_reg[0] <= v3_reg;
            for (int j = 1; j < SQRT_LAT; j++) va_reg[j] <= va_reg[j-1];
            v4_reg    <= va_reg[SQRT_LAT-1];
            v5_reg    <= v4_reg;
            vb_reg[0] <= v5_reg;
            for (int j = 1; j < DIV_LAT; j++) vb_reg[j] <= vb_reg[j-1];
            m_valid_reg <= vb_reg[DIV_LAT-1];
        end
    end

    // Saturate a magnitude quotient to Q1.15 and apply the sign.
    function automatic logic [15:0] sat_sign(input logic [QW-1:0] q, input logic ovf,
                                             input logic neg);
        logic [15:0] r;
        if (neg) begin
            if (ovf || q > QW'(32768)) r = 16'h8000;
            else                       r = 16'(~q + QW'(1));
        end else begin
            if (ovf || q > QW'(32767)) r = 16'h7FFF;
            else                       r = q[15:0];
        end
        return r;
    endfunction

    side_t     sf;
    jrdz_out_t res;
    logic      kill;
    assign sf   = side_b_reg[DIV_LAT-1];
    assign kill = sf.dead || sf.zero;
    always_comb begin
        res.in_dead_zone = sf.dead;
        res.scaled_x     = kill ? 16'sd0 : sat_sign(qsx, tsx, sf.nx);
        res.scaled_y     = kill ? 16'sd0 : sat_sign(qsy, tsy, sf.ny);
        res.dir_x        = kill ? 16'sd0 : sat_sign(qdx, tdx, sf.nx);
        res.dir_y        = kill ? 16'sd0 : sat_sign(qdy, tdy, sf.ny);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= res;
        end
    end

endmodule
